### rtl/core/ddr_pkg.sv
// ----------------------------------------------------------------------------
// ddr_pkg
// Types and constants shared by the decimal digit register unit.
// ----------------------------------------------------------------------------
package ddr_pkg;

  localparam int VALUE_W = 31;
  localparam int BCD_W   = 32;
  localparam int REV_W   = 27;
  localparam int DIGIT_W = 4;

  localparam logic [2:0] OP_LOAD  = 3'd0;
  localparam logic [2:0] OP_WRITE = 3'd1;
  localparam logic [2:0] OP_SYNC  = 3'd2;
  localparam logic [2:0] OP_PUSH  = 3'd3;
  localparam logic [2:0] OP_POP   = 3'd4;

  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

  // floor(v * DIV10_MAGIC / 2^DIV10_SHIFT) == v / 10 for any 32-bit v
  localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
  localparam int          DIV10_SHIFT = 35;

  typedef struct packed {
    logic [2:0]         op;
    logic [VALUE_W-1:0] load_value;
    logic [2:0]         digit_index;
    logic [3:0]         new_digit;
    logic [3:0]         pop_count;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] current_value;
    logic [BCD_W-1:0]   bcd_digits;
    logic [REV_W-1:0]   reversed_value;
    logic               overflow;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_MUL,
    ST_DIV_UPD,
    ST_CLEAR,
    ST_DABBLE,
    ST_ROTATE,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_DABBLE,
    CELL_ROTATE,
    CELL_WRITE
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t         mode;
    logic [DIGIT_W-1:0] wr_digit;
  } cell_ctl_t;

endpackage

### rtl/core/ddr_cell.sv
// ----------------------------------------------------------------------------
// ddr_cell
// One decimal digit: clear, shift-and-add-3 step, rotate from neighbor, direct write.
// ----------------------------------------------------------------------------
module ddr_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  ddr_pkg::cell_ctl_t           ctl,
  input  logic                         wr_en,
  input  logic                         carry_in,
  input  logic [ddr_pkg::DIGIT_W-1:0]  rot_in,
  output logic [ddr_pkg::DIGIT_W-1:0]  digit,
  output logic                         carry_out
);

  logic [ddr_pkg::DIGIT_W-1:0] adj;

  always_comb begin
    adj       = (digit >= 4'd5) ? 4'(digit + 4'd3) : digit;
    carry_out = adj[3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit <= '0;
    end else begin
      unique case (ctl.mode)
        ddr_pkg::CELL_CLEAR:  digit <= '0;
        ddr_pkg::CELL_DABBLE: digit <= {adj[2:0], carry_in};
        ddr_pkg::CELL_ROTATE: digit <= rot_in;
        ddr_pkg::CELL_WRITE: begin
          if (wr_en) begin
            digit <= ctl.wr_digit;
          end
        end
        default: digit <= digit;
      endcase
    end
  end

endmodule

### rtl/core/ddr_chain.sv
// ----------------------------------------------------------------------------
// ddr_chain
// Row of digit cells; carries ripple upward during conversion, digits
// rotate upward with the top digit wrapping to the bottom.
// ----------------------------------------------------------------------------
module ddr_chain #(
  parameter int DIGITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ddr_pkg::cell_ctl_t                  ctl,
  input  logic [DIGITS-1:0]                   wr_sel,
  input  logic                                carry_in,
  output logic [DIGITS*ddr_pkg::DIGIT_W-1:0]  digits,
  output logic [ddr_pkg::DIGIT_W-1:0]         top_digit
);

  logic [DIGITS-1:0]           carry;
  logic [ddr_pkg::DIGIT_W-1:0] dig [DIGITS];

  for (genvar i = 0; i < DIGITS; i++) begin : g_cell
    logic                        c_in;
    logic [ddr_pkg::DIGIT_W-1:0] r_in;

    if (i == 0) begin : g_first
      assign c_in = carry_in;
      assign r_in = dig[DIGITS-1];
    end else begin : g_rest
      assign c_in = carry[i-1];
      assign r_in = dig[i-1];
    end

    ddr_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .wr_en     (wr_sel[i]),
      .carry_in  (c_in),
      .rot_in    (r_in),
      .digit     (dig[i]),
      .carry_out (carry[i])
    );

    assign digits[i*ddr_pkg::DIGIT_W +: ddr_pkg::DIGIT_W] = dig[i];
  end

  // carry out of the top cell is dropped: digits hold the value mod 10^DIGITS
  assign top_digit = carry[DIGITS-1] ? dig[DIGITS-1] : dig[DIGITS-1];

endmodule

### rtl/core/decimal_digit_register_unit.sv
// ----------------------------------------------------------------------------
// decimal_digit_register_unit
// Binary value with its low decimal digits: load, digit write, sync, push, pop.
// ----------------------------------------------------------------------------
// One item at a time: busy is high from the accepting edge until the result
// strobe, and done is high for exactly one cycle with the result, which the
// receiver cannot stall. Write digit, sync, unused codes and a push that
// changes nothing (digit above nine or overflow) go straight to the
// DIGITS-step rotation that forms the reversed number and the sync value;
// load and an accepted push first make a 31-step shift-and-add-3 pass
// through the digit cells; pop first divides the value by ten pop_count
// times, each division being one registered reciprocal multiply plus a
// shift, and then makes the same pass.
// ----------------------------------------------------------------------------
module decimal_digit_register_unit #(
  parameter int DIGITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  ddr_pkg::in_item_t  request,
  output logic               busy,
  output logic               done,
  output ddr_pkg::out_item_t result
);

  localparam int         STEP_W    = 5;
  localparam logic [4:0] LAST_DAB  = 5'(ddr_pkg::VALUE_W - 1);
  localparam logic [4:0] LAST_ROT  = 5'(DIGITS - 1);
  localparam logic [3:0] DIGITS_N  = 4'(DIGITS);

  ddr_pkg::state_t   state, state_next;
  ddr_pkg::in_item_t item;

  logic [ddr_pkg::VALUE_W-1:0]          held;
  logic [ddr_pkg::VALUE_W-1:0]          shreg;
  logic [62:0]                          prod;
  logic [3:0]                           cnt;
  logic [STEP_W-1:0]                    step;
  logic [ddr_pkg::REV_W-1:0]            rev, rev_next;
  logic [ddr_pkg::REV_W-1:0]            pwr, pwr_next;
  logic [ddr_pkg::VALUE_W-1:0]          sync_acc, sync_next;
  logic                                 ovf;

  logic [34:0]                          push_sum;
  logic                                 push_ovf;
  logic                                 digit_ok;
  logic                                 idx_ok;

  ddr_pkg::cell_ctl_t                   ctl;
  logic [DIGITS-1:0]                    wr_sel;
  logic [DIGITS*ddr_pkg::DIGIT_W-1:0]   digits;
  logic [ddr_pkg::DIGIT_W-1:0]          top_digit;

  ddr_chain #(.DIGITS(DIGITS)) u_chain (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .wr_sel    (wr_sel),
    .carry_in  (shreg[ddr_pkg::VALUE_W-1]),
    .digits    (digits),
    .top_digit (top_digit)
  );

  // item decode and rotate-phase arithmetic
  always_comb begin
    digit_ok  = request.new_digit <= ddr_pkg::DIGIT_MAX;
    idx_ok    = {1'b0, request.digit_index} < DIGITS_N;
    push_sum  = 35'({held, 3'b000}) + 35'({held, 1'b0}) + 35'(request.new_digit);
    push_ovf  = push_sum[34:31] != 4'd0;
    rev_next  = ddr_pkg::REV_W'(rev + ddr_pkg::REV_W'(pwr * top_digit));
    pwr_next  = ddr_pkg::REV_W'({pwr, 3'b000} + {pwr, 1'b0});
    sync_next = ddr_pkg::VALUE_W'({sync_acc, 3'b000} + {sync_acc, 1'b0}
                                  + ddr_pkg::VALUE_W'(top_digit));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ddr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    busy         = 1'b1;
    done         = 1'b0;
    ctl.mode     = ddr_pkg::CELL_HOLD;
    ctl.wr_digit = request.new_digit;
    wr_sel       = '0;
    unique case (state)
      ddr_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          unique case (request.op)
            ddr_pkg::OP_LOAD: state_next = ddr_pkg::ST_CLEAR;
            ddr_pkg::OP_WRITE: begin
              ctl.mode   = ddr_pkg::CELL_WRITE;
              wr_sel     = (idx_ok && digit_ok) ?
                           DIGITS'(DIGITS'(1) << request.digit_index) : '0;
              state_next = ddr_pkg::ST_ROTATE;
            end
            ddr_pkg::OP_PUSH: begin
              state_next = (digit_ok && !push_ovf) ? ddr_pkg::ST_CLEAR
                                                   : ddr_pkg::ST_ROTATE;
            end
            ddr_pkg::OP_POP: state_next = ddr_pkg::ST_DIV_MUL;
            default:         state_next = ddr_pkg::ST_ROTATE;
          endcase
        end
      end
      ddr_pkg::ST_DIV_MUL: begin
        state_next = (cnt == 4'd0) ? ddr_pkg::ST_CLEAR : ddr_pkg::ST_DIV_UPD;
      end
      ddr_pkg::ST_DIV_UPD: state_next = ddr_pkg::ST_DIV_MUL;
      ddr_pkg::ST_CLEAR: begin
        ctl.mode   = ddr_pkg::CELL_CLEAR;
        state_next = ddr_pkg::ST_DABBLE;
      end
      ddr_pkg::ST_DABBLE: begin
        ctl.mode = ddr_pkg::CELL_DABBLE;
        if (step == LAST_DAB) begin
          state_next = ddr_pkg::ST_ROTATE;
        end
      end
      ddr_pkg::ST_ROTATE: begin
        ctl.mode = ddr_pkg::CELL_ROTATE;
        if (step == LAST_ROT) begin
          state_next = ddr_pkg::ST_DONE;
        end
      end
      ddr_pkg::ST_DONE: begin
        done       = 1'b1;
        state_next = ddr_pkg::ST_IDLE;
      end
      default: state_next = ddr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
      ovf  <= 1'b0;
    end else begin
      unique case (state)
        ddr_pkg::ST_IDLE: begin
          if (start) begin
            item     <= request;
            rev      <= '0;
            pwr      <= ddr_pkg::REV_W'(1);
            sync_acc <= '0;
            step     <= '0;
            cnt      <= request.pop_count;
            ovf      <= (request.op == ddr_pkg::OP_PUSH) && digit_ok && push_ovf;
            if (request.op == ddr_pkg::OP_LOAD) begin
              held <= request.load_value;
            end else if (request.op == ddr_pkg::OP_PUSH && digit_ok && !push_ovf) begin
              held <= push_sum[ddr_pkg::VALUE_W-1:0];
            end
          end
        end
        ddr_pkg::ST_DIV_MUL: prod <= held * ddr_pkg::DIV10_MAGIC;
        ddr_pkg::ST_DIV_UPD: begin
          held <= ddr_pkg::VALUE_W'(prod >> ddr_pkg::DIV10_SHIFT);
          cnt  <= cnt - 4'd1;
        end
        ddr_pkg::ST_CLEAR: begin
          shreg <= held;
          step  <= '0;
        end
        ddr_pkg::ST_DABBLE: begin
          shreg <= {shreg[ddr_pkg::VALUE_W-2:0], 1'b0};
          step  <= (step == LAST_DAB) ? '0 : STEP_W'(step + 5'd1);
        end
        ddr_pkg::ST_ROTATE: begin
          rev      <= rev_next;
          pwr      <= pwr_next;
          sync_acc <= sync_next;
          step     <= STEP_W'(step + 5'd1);
          if (step == LAST_ROT && item.op == ddr_pkg::OP_SYNC) begin
            held <= sync_next;
          end
        end
        default: ;
      endcase
    end
  end

  // result packing: nibble i carries digit i for the low eight digits
  for (genvar i = 0; i < 8; i++) begin : g_bcd
    if (i < DIGITS) begin : g_on
      assign result.bcd_digits[i*4 +: 4] = digits[i*ddr_pkg::DIGIT_W +: ddr_pkg::DIGIT_W];
    end else begin : g_off
      assign result.bcd_digits[i*4 +: 4] = 4'd0;
    end
  end

  assign result.current_value  = held;
  assign result.reversed_value = rev;
  assign result.overflow       = ovf;

endmodule
